### rtl/core/lfu_pkg.sv
package lfu_pkg;

  typedef enum logic [2:0] {
    ST_GET_HIT   = 3'd0,
    ST_GET_MISS  = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_EXISTED   = 3'd3,
    ST_EVICTED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_CLEAR,
    S_INSERT,
    S_DONE
  } ctrl_state_t;

  localparam int unsigned USES_BITS = 32;
  localparam int unsigned CFG_BITS  = 5;
  localparam int unsigned CNT_BITS  = 5;

  typedef struct packed {
    logic load;     // capture request
    logic lookup;   // register key compare
    logic hit_get;  // bump count, latch value
    logic scan;     // step minimum search
    logic scan_clr; // restart minimum search
    logic evict;    // clear minimum group
    logic insert;   // write new entry
  } dp_cmd_t;

  typedef struct packed {
    logic action;
    logic hit;
    logic full;
    logic scan_done;
  } dp_sts_t;

endpackage

### rtl/core/lfu_datapath.sv
module lfu_datapath
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CFG_BITS-1:0]   max_entries,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  in_action,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic [VALUE_BITS-1:0] rd_value,
  output logic [CNT_BITS-1:0]   evicted
);

  localparam int unsigned IDX_BITS = $clog2(ENTRIES);
  localparam int unsigned OCC_BITS = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0]    valid_r;
  logic [KEY_BITS-1:0]   key_r   [ENTRIES];
  logic [VALUE_BITS-1:0] val_r   [ENTRIES];
  logic [USES_BITS-1:0]  uses_r  [ENTRIES];
  logic [OCC_BITS-1:0]   occ_r;

  logic                  act_r;
  logic [KEY_BITS-1:0]   rkey_r;
  logic [VALUE_BITS-1:0] rval_r;
  logic [ENTRIES-1:0]    match_r;
  logic [VALUE_BITS-1:0] rd_value_r;
  logic [CNT_BITS-1:0]   evicted_r;
  logic [IDX_BITS:0]     scan_idx_r;
  logic                  any_r;
  logic [USES_BITS-1:0]  low_r;

  logic [ENTRIES-1:0]    match_nxt;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [IDX_BITS-1:0]   free_idx;
  logic [ENTRIES-1:0]    evict_mask;
  logic [OCC_BITS-1:0]   evict_num;
  logic [OCC_BITS-1:0]   limit;
  logic [IDX_BITS-1:0]   sidx;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && (key_r[i] == rkey_r);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) hit_idx = IDX_BITS'(i);
      if (!valid_r[i]) free_idx = IDX_BITS'(i);
    end
  end

  always_comb begin
    evict_num = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      evict_mask[i] = valid_r[i] && any_r && (uses_r[i] == low_r);
      evict_num     = evict_num + OCC_BITS'(evict_mask[i]);
    end
  end

  // 0 acts as 1, above ENTRIES acts as ENTRIES
  always_comb begin
    if (max_entries == '0) begin
      limit = OCC_BITS'(1);
    end else if (32'(max_entries) > ENTRIES) begin
      limit = OCC_BITS'(ENTRIES);
    end else begin
      limit = OCC_BITS'(max_entries);
    end
  end

  assign sidx = scan_idx_r[IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      occ_r      <= '0;
      scan_idx_r <= '0;
      any_r      <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) uses_r[i] <= '0;
    end else begin
      if (cmd.scan_clr) begin
        scan_idx_r <= '0;
        any_r      <= 1'b0;
      end else if (cmd.scan) begin
        if (valid_r[sidx] && (!any_r || uses_r[sidx] < low_r)) begin
          low_r <= uses_r[sidx];
          any_r <= 1'b1;
        end
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cmd.hit_get && uses_r[hit_idx] != '1) begin
        uses_r[hit_idx] <= uses_r[hit_idx] + 1'b1;
      end
      if (cmd.evict) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (evict_mask[i]) begin
            valid_r[i] <= 1'b0;
            uses_r[i]  <= '0;
          end
        end
        occ_r <= occ_r - evict_num;
      end
      if (cmd.insert && !valid_r[free_idx]) begin
        valid_r[free_idx] <= 1'b1;
        uses_r[free_idx]  <= USES_BITS'(1);
        occ_r             <= occ_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r      <= in_action;
      rkey_r     <= in_key;
      rval_r     <= in_value;
      rd_value_r <= '0;
      evicted_r  <= '0;
    end
    if (cmd.lookup) match_r <= match_nxt;
    if (cmd.hit_get) rd_value_r <= val_r[hit_idx];
    if (cmd.evict) begin
      evicted_r <= (32'(evict_num) > 31) ? '1 : CNT_BITS'(evict_num);
    end
    if (cmd.insert && !valid_r[free_idx]) begin
      key_r[free_idx] <= rkey_r;
      val_r[free_idx] <= rval_r;
    end
  end

  assign sts.action    = act_r;
  assign sts.hit       = |match_r;
  assign sts.full      = occ_r >= limit;
  assign sts.scan_done = scan_idx_r == (IDX_BITS+1)'(ENTRIES);
  assign rd_value      = rd_value_r;
  assign evicted       = evicted_r;

endmodule

### rtl/core/lfu_ctrl.sv
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    out_stall,
  output logic    out_valid,
  output status_t status,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  ctrl_state_t state_r, state_nxt;
  status_t     status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_GET_MISS;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.lookup   = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.action) begin
          cmd.hit_get = sts.hit;
          status_nxt  = sts.hit ? ST_GET_HIT : ST_GET_MISS;
          state_nxt   = S_DONE;
        end else if (sts.hit) begin
          status_nxt = ST_EXISTED;
          state_nxt  = S_DONE;
        end else if (!sts.full) begin
          status_nxt = ST_INSERTED;
          state_nxt  = S_INSERT;
        end else if (sts.scan_done) begin
          status_nxt = ST_EVICTED;
          state_nxt  = S_CLEAR;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_CLEAR: begin
        cmd.evict = 1'b1;
        state_nxt = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign status = status_r;

endmodule

### rtl/core/lfu_cache_table_unit.sv
// A get or an ignored set passes through the capture, key match and decision states; a plain
// insert adds a write state, and an insert that evicts first scans for the minimum use count
// (one minimum-search step per entry), then clears that minimum group and writes the entry.
// One request in flight: in_stall stays high until the result is taken; out_stall holds it.
// Reset (synchronous, rst_n low) clears all valid bits, use counts,
// occupancy and sets max_entries to 16.
module lfu_cache_table_unit
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_BITS-1:0]   cfg_max_entries,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic [VALUE_BITS-1:0] out_read_value,
  output logic [CNT_BITS-1:0]   out_evicted_count
);

  logic [CFG_BITS-1:0] max_entries_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) max_entries_r <= CFG_BITS'(16);
    else if (cfg_we) max_entries_r <= cfg_max_entries;
  end

  lfu_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_stall, .out_valid,
    .status, .cmd, .sts
  );

  lfu_datapath #(
    .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk, .rst_n, .max_entries(max_entries_r), .cmd, .sts,
    .in_action, .in_key, .in_value,
    .rd_value(out_read_value), .evicted(out_evicted_count)
  );

  assign out_status = status;

endmodule

### rtl/core/lfu_checker.sv
module lfu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic [4:0] out_evicted_count
);

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'd4) else $error("bad status");

  a_evict_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 3'd4 |-> out_evicted_count == '0)
    else $error("eviction count without eviction");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken with result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind lfu_cache_table_unit lfu_checker u_lfu_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_status, .out_evicted_count
);
